@@ sv/sqtsg_pkg.sv @@
// ----------------------------------------------------------------------------
// sqtsg_pkg
// Shared types and constants for the quiet-tail and spike gate block.
// ----------------------------------------------------------------------------
package sqtsg_pkg;

  // default spectrum capacity in bins
  localparam int SQ_MAX_BINS = 512;

  // fixed field widths
  localparam int PWR_W  = 31;
  localparam int QBIN_W = 9;
  localparam int CUT_W  = 10;

  // constant factors of the threshold compares
  localparam int QUIET_MUL  = 100;  // power*100 < 2*max_power
  localparam int NEIGH_MUL  = 100;  // neighbor*100 < 15*p
  localparam int SPIKE_MUL  = 15;
  localparam int THR_MUL    = 20;   // p*20 > max_power*3
  localparam int THR_MAX    = 3;

  // product widths
  localparam int P100_W = PWR_W + 7;
  localparam int P15_W  = PWR_W + 4;
  localparam int P20_W  = PWR_W + 5;
  localparam int M3_W   = PWR_W + 2;

  // item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // result kinds
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;

  // evaluation sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_MERGE,
    ST_CUT,
    ST_SPIKE,
    ST_SPIKE_DRAIN,
    ST_DONE
  } eval_state_t;

  // status from the evaluation sequencer to the top level
  typedef struct packed {
    logic busy;
    logic cut_load;
    logic done;
  } eval_stat_t;

endpackage

@@ sv/sqtsg_mem.sv @@
// ----------------------------------------------------------------------------
// sqtsg_mem
// Bin power memory and gate flag memory, one write and one registered read
// port each.
// ----------------------------------------------------------------------------
module sqtsg_mem
  import sqtsg_pkg::*;
#(
  parameter int MAX_BINS = SQ_MAX_BINS,
  localparam int AW = $clog2(MAX_BINS)
) (
  input  logic             clk,
  // power memory
  input  logic             pw_en,
  input  logic [AW-1:0]    pw_addr,
  input  logic [PWR_W-1:0] pw_data,
  input  logic             pr_en,
  input  logic [AW-1:0]    pr_addr,
  output logic [PWR_W-1:0] pr_data,
  // gate flag memory
  input  logic             gw_en,
  input  logic [AW-1:0]    gw_addr,
  input  logic             gw_data,
  input  logic             gr_en,
  input  logic [AW-1:0]    gr_addr,
  output logic             gr_data
);

  logic [PWR_W-1:0] pwr_mem [MAX_BINS];
  logic             gate_mem [MAX_BINS];
  logic [PWR_W-1:0] pr_data_r;
  logic             gr_data_r;

  // power store
  always_ff @(posedge clk) begin
    if (pw_en) begin
      pwr_mem[pw_addr] <= pw_data;
    end
    if (pr_en) begin
      pr_data_r <= pwr_mem[pr_addr];
    end
  end

  // gate flags
  always_ff @(posedge clk) begin
    if (gw_en) begin
      gate_mem[gw_addr] <= gw_data;
    end
    if (gr_en) begin
      gr_data_r <= gate_mem[gr_addr];
    end
  end

  assign pr_data = pr_data_r;
  assign gr_data = gr_data_r;

endmodule

@@ sv/sqtsg_eval.sv @@
// ----------------------------------------------------------------------------
// sqtsg_eval
// Evaluation sequencer: a quiet-run scan over the stored bins, the tail cut
// decision, then a spike pass that writes every bin's gate flag.
// ----------------------------------------------------------------------------
module sqtsg_eval
  import sqtsg_pkg::*;
#(
  parameter int MAX_BINS = SQ_MAX_BINS,
  localparam int AW = $clog2(MAX_BINS),
  localparam int CW = $clog2(MAX_BINS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CW-1:0]    bin_count,
  input  logic [PWR_W-1:0] max_power,
  output eval_stat_t       stat,
  output logic [CW-1:0]    tail_cut,
  // power memory read
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  logic [PWR_W-1:0] rd_data,
  // gate memory write
  output logic             gate_we,
  output logic [AW-1:0]    gate_addr,
  output logic             gate_wdata
);

  eval_state_t state_r, state_nxt;

  logic [CW-1:0]     j_r;
  logic              s1_scan_r;
  logic              s1_spike_r;
  logic [CW-1:0]     s1_idx_r;
  logic [CW-1:0]     run_r;
  logic [CW-1:0]     best_len_r;
  logic [CW-1:0]     best_start_r;
  logic [CW-1:0]     tail_r;
  logic [P100_W-1:0] pk100_r;
  logic [P100_W-1:0] c_k100_r;
  logic [P15_W-1:0]  c_k15_r;
  logic [P20_W-1:0]  c_k20_r;

  logic              quiet;
  logic [P100_W-1:0] d100;
  logic [P100_W-1:0] quiet_ref;
  logic [PWR_W-1:0]  k;
  logic [P100_W-1:0] k100;
  logic [P15_W-1:0]  k15;
  logic [P20_W-1:0]  k20;
  logic [M3_W-1:0]   max3;
  logic [CW-1:0]     bin_i;
  logic              spike;
  logic              gate_bit;
  logic              cut;
  logic [CW:0]       run_end;

  // quiet test on the scanned bin
  assign d100      = P100_W'(rd_data) * P100_W'(QUIET_MUL);
  assign quiet_ref = P100_W'({max_power, 1'b0});
  assign quiet     = d100 < quiet_ref;

  // kept power of the bin arriving in the spike pass, tail bins read zero
  assign k    = (s1_idx_r < tail_r) ? rd_data : '0;
  assign k100 = P100_W'(k) * P100_W'(NEIGH_MUL);
  assign k15  = P15_W'(k) * P15_W'(SPIKE_MUL);
  assign k20  = P20_W'(k) * P20_W'(THR_MUL);
  assign max3 = M3_W'(max_power) * M3_W'(THR_MAX);

  // spike test for the bin before the arriving one
  assign bin_i = s1_idx_r - CW'(1);
  assign spike = (s1_idx_r >= CW'(2)) &&
                 ((CW+1)'(s1_idx_r) + (CW+1)'(1) < (CW+1)'(bin_count)) &&
                 (c_k20_r > P20_W'(max3)) &&
                 (pk100_r < P100_W'(c_k15_r)) &&
                 (k100 < P100_W'(c_k15_r));
  assign gate_bit = (bin_i >= tail_r) || spike;

  // tail cut decision on the longest run
  assign run_end = (CW+1)'(best_start_r) + (CW+1)'(best_len_r);
  assign cut     = (CW+1)'(best_start_r) > ((CW+1)'(bin_count) - run_end);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        if (bin_count < CW'(2)) state_nxt = ST_MERGE;
        else                    state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (j_r == bin_count - CW'(1)) state_nxt = ST_SCAN_DRAIN;
      end
      ST_SCAN_DRAIN:  state_nxt = ST_MERGE;
      ST_MERGE:       state_nxt = ST_CUT;
      ST_CUT:         state_nxt = ST_SPIKE;
      ST_SPIKE: begin
        if (j_r == bin_count) state_nxt = ST_SPIKE_DRAIN;
      end
      ST_SPIKE_DRAIN: state_nxt = ST_DONE;
      ST_DONE:        state_nxt = ST_IDLE;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs, the cut is handed over once tail_r holds it
  always_comb begin
    stat.busy     = 1'b1;
    stat.cut_load = 1'b0;
    stat.done     = 1'b0;
    rd_en         = 1'b0;
    unique case (state_r)
      ST_IDLE:        stat.busy = 1'b0;
      ST_SCAN:        rd_en = 1'b1;
      ST_SPIKE:       rd_en = 1'b1;
      ST_SPIKE_DRAIN: stat.cut_load = 1'b1;
      ST_DONE:        stat.done = 1'b1;
      default: begin
      end
    endcase
  end

  assign rd_addr    = j_r[AW-1:0];
  assign tail_cut   = tail_r;
  assign gate_we    = s1_spike_r && (s1_idx_r != '0);
  assign gate_addr  = bin_i[AW-1:0];
  assign gate_wdata = gate_bit;

  // read pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_scan_r  <= 1'b0;
      s1_spike_r <= 1'b0;
    end else begin
      s1_scan_r  <= (state_r == ST_SCAN);
      s1_spike_r <= (state_r == ST_SPIKE);
    end
  end

  // read index
  always_ff @(posedge clk) begin
    s1_idx_r <= j_r;
    case (state_r)
      ST_SETUP: j_r <= CW'(1);
      ST_CUT:   j_r <= '0;
      ST_SCAN,
      ST_SPIKE: j_r <= j_r + CW'(1);
      default:  j_r <= j_r;
    endcase
  end

  // quiet run tracking, merge and tail cut
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r        <= '0;
      best_len_r   <= '0;
      best_start_r <= '0;
      tail_r       <= '0;
    end else if (state_r == ST_SETUP) begin
      run_r        <= '0;
      best_len_r   <= '0;
      best_start_r <= '0;
    end else if (s1_scan_r) begin
      if (quiet) begin
        run_r <= run_r + CW'(1);
      end else begin
        if (run_r > best_len_r) begin
          best_len_r   <= run_r;
          best_start_r <= s1_idx_r - run_r;
        end
        run_r <= '0;
      end
    end else if (state_r == ST_MERGE) begin
      if (run_r > best_len_r) begin
        best_len_r   <= run_r;
        best_start_r <= bin_count - run_r;
      end
    end else if (state_r == ST_CUT) begin
      tail_r <= cut ? best_start_r : bin_count;
    end
  end

  // spike window: previous bin after gating, current bin products
  always_ff @(posedge clk) begin
    if (s1_spike_r) begin
      pk100_r  <= (s1_idx_r != '0 && gate_bit) ? '0 : c_k100_r;
      c_k100_r <= k100;
      c_k15_r  <= k15;
      c_k20_r  <= k20;
    end
  end

  // gate flags are written only by the spike pass
  a_gate_we_in_spike: assert property (@(posedge clk) disable iff (!rst_n)
    gate_we |-> (state_r == ST_SPIKE || state_r == ST_SPIKE_DRAIN))
    else $error("gate write outside spike pass");

  // the cut never lies beyond the bin count
  a_tail_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CUT) |=> (tail_r <= bin_count))
    else $error("tail cut beyond bin count");

  // the best run stays inside the stored bins
  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CUT) |-> (run_end <= (CW+1)'(bin_count)))
    else $error("best run beyond bin count");

  // done only follows the spike drain
  a_done_order: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> $past(state_r == ST_SPIKE_DRAIN))
    else $error("evaluation done out of order");

endmodule

@@ sv/spectral_quiet_tail_and_spike_gate_top.sv @@
// ----------------------------------------------------------------------------
// spectral_quiet_tail_and_spike_gate_top
// Quiet-tail and spike gate over half a power spectrum held in bin memory.
// ----------------------------------------------------------------------------
// Usage: an item is taken at a clock edge with start high and busy low.
// in_func selects a load (next bin power, in_last on the final bin) or a
// query of bin in_query_bin. cfg_we/cfg_wdata write max_power while idle.
// Loads without last return nothing; loads beyond MAX_BINS are dropped and
// reported as overflow. A load with last starts evaluation: busy stays high
// while the sequencer reads the stored bin powers in the run scan and again
// in the spike pass.
// The summary (out_kind 0, out_cut_start) shows in the first cycle with busy
// low again. A query returns its answer in the cycle after it is taken, set by
// the registered memory read, and queries may follow back to back.
// Each result shows on the out_ ports for one cycle with out_strobe high;
// the receiver always takes it. Reset clears the bin count, cut, overflow
// and max_power (to 1); the memories are not cleared.
// ----------------------------------------------------------------------------
module spectral_quiet_tail_and_spike_gate_top
  import sqtsg_pkg::*;
#(
  parameter int MAX_BINS = SQ_MAX_BINS
) (
  input  logic              clk,
  input  logic              rst_n,
  // item input
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [PWR_W-1:0]  in_power,
  input  logic              in_last,
  input  logic [QBIN_W-1:0] in_query_bin,
  // configuration
  input  logic              cfg_we,
  input  logic [PWR_W-1:0]  cfg_wdata,
  // results
  output logic              out_strobe,
  output logic              out_kind,
  output logic [CUT_W-1:0]  out_cut_start,
  output logic [QBIN_W-1:0] out_bin_index,
  output logic              out_gated,
  output logic [PWR_W-1:0]  out_kept_power,
  output logic              out_overflow
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int CW = $clog2(MAX_BINS + 1);

  logic [PWR_W-1:0]  max_power_r;
  logic [CW-1:0]     bin_count_r;
  logic [CW-1:0]     tail_cut_r;
  logic              lost_r;
  logic              frame_done_r;
  logic              o_strobe_r;
  logic              o_kind_r;
  logic [CW-1:0]     o_cut_r;
  logic [QBIN_W-1:0] o_bin_r;
  logic              o_hit_r;
  logic              o_lost_r;

  eval_stat_t        ev_stat;
  logic [CW-1:0]     ev_tail;
  logic              ev_rd_en;
  logic [AW-1:0]     ev_rd_addr;
  logic              ev_gate_we;
  logic [AW-1:0]     ev_gate_addr;
  logic              ev_gate_wdata;

  logic              take;
  logic              take_load;
  logic              take_query;
  logic [CW-1:0]     count_eff;
  logic              store_ok;
  logic              q_hit;
  logic [CW+QBIN_W-1:0] q_wide;
  logic [CW+CUT_W-1:0]  cut_wide;

  logic              pw_en;
  logic              pr_en;
  logic [AW-1:0]     pr_addr;
  logic [PWR_W-1:0]  pr_data;
  logic              gw_en;
  logic [AW-1:0]     gw_addr;
  logic              gw_data;
  logic              gr_data;

  // item handshake
  assign busy       = ev_stat.busy;
  assign take       = start && !busy;
  assign take_load  = take && (in_func == FUNC_LOAD);
  assign take_query = take && (in_func == FUNC_QUERY);

  // a load after a summary starts a fresh spectrum
  assign count_eff = frame_done_r ? '0 : bin_count_r;
  assign store_ok  = count_eff < CW'(MAX_BINS);

  // query address and range check
  assign q_wide = {{CW{1'b0}}, in_query_bin};
  assign q_hit  = q_wide < (CW+QBIN_W)'(bin_count_r);

  // memory port selection between item handling and evaluation
  assign pw_en   = take_load && store_ok;
  assign pr_en   = ev_stat.busy ? ev_rd_en : take_query;
  assign pr_addr = ev_stat.busy ? ev_rd_addr : q_wide[AW-1:0];
  assign gw_en   = ev_stat.busy ? ev_gate_we : (take_load && store_ok);
  assign gw_addr = ev_stat.busy ? ev_gate_addr : count_eff[AW-1:0];
  assign gw_data = ev_stat.busy ? ev_gate_wdata : 1'b0;

  sqtsg_mem #(
    .MAX_BINS (MAX_BINS)
  ) u_mem (
    .clk     (clk),
    .pw_en   (pw_en),
    .pw_addr (count_eff[AW-1:0]),
    .pw_data (in_power),
    .pr_en   (pr_en),
    .pr_addr (pr_addr),
    .pr_data (pr_data),
    .gw_en   (gw_en),
    .gw_addr (gw_addr),
    .gw_data (gw_data),
    .gr_en   (take_query),
    .gr_addr (q_wide[AW-1:0]),
    .gr_data (gr_data)
  );

  sqtsg_eval #(
    .MAX_BINS (MAX_BINS)
  ) u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (take_load && in_last),
    .bin_count  (bin_count_r),
    .max_power  (max_power_r),
    .stat       (ev_stat),
    .tail_cut   (ev_tail),
    .rd_en      (ev_rd_en),
    .rd_addr    (ev_rd_addr),
    .rd_data    (pr_data),
    .gate_we    (ev_gate_we),
    .gate_addr  (ev_gate_addr),
    .gate_wdata (ev_gate_wdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_power_r <= PWR_W'(1);
    end else if (cfg_we) begin
      max_power_r <= cfg_wdata;
    end
  end

  // spectrum bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r  <= '0;
      tail_cut_r   <= '0;
      lost_r       <= 1'b0;
      frame_done_r <= 1'b0;
    end else if (take_load) begin
      bin_count_r  <= store_ok ? count_eff + CW'(1) : count_eff;
      lost_r       <= (lost_r && !frame_done_r) || !store_ok;
      tail_cut_r   <= frame_done_r ? '0 : tail_cut_r;
      frame_done_r <= in_last;
    end else if (ev_stat.cut_load) begin
      tail_cut_r <= ev_tail;
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_strobe_r <= 1'b0;
    end else begin
      o_strobe_r <= take_query || ev_stat.done;
    end
  end

  always_ff @(posedge clk) begin
    if (take_query) begin
      o_kind_r <= KIND_QUERY;
      o_cut_r  <= tail_cut_r;
      o_bin_r  <= in_query_bin;
      o_hit_r  <= q_hit;
      o_lost_r <= lost_r;
    end else if (ev_stat.done) begin
      o_kind_r <= KIND_SUMMARY;
      o_cut_r  <= tail_cut_r;
      o_bin_r  <= '0;
      o_hit_r  <= 1'b0;
      o_lost_r <= lost_r;
    end
  end

  // result ports, gate flag and power come from the registered reads
  assign cut_wide       = {{CUT_W{1'b0}}, o_cut_r};
  assign out_strobe     = o_strobe_r;
  assign out_kind       = o_kind_r;
  assign out_cut_start  = cut_wide[CUT_W-1:0];
  assign out_bin_index  = o_bin_r;
  assign out_gated      = o_hit_r && gr_data;
  assign out_kept_power = (o_hit_r && !gr_data) ? pr_data : '0;
  assign out_overflow   = o_lost_r;

endmodule

@@ bench/tb_spectral_quiet_tail_and_spike_gate_top.sv @@
// ----------------------------------------------------------------------------
// tb_spectral_quiet_tail_and_spike_gate_top
// Self-checking bench for the quiet-tail and spike gate. Spectra are loaded
// bin by bin, then queried. A built-in model of the gating rules predicts each
// summary and query answer, and the monitor compares them field by field. A
// short table of directed items comes first, followed by random spectra
// (quiet runs, spikes, threshold edges, noise, overflow) under several
// max_power settings. The sender idles at random.
// ----------------------------------------------------------------------------
module tb_spectral_quiet_tail_and_spike_gate_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sqtsg_pkg::*;

  localparam int RANDOM_ITEMS = 1070;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 32;
  localparam int CFG_SETTLE   = 4;

  // one result item as seen on the out_ ports
  typedef struct packed {
    logic              kind;
    logic [CUT_W-1:0]  cut_start;
    logic [QBIN_W-1:0] bin_index;
    logic              gated;
    logic [PWR_W-1:0]  kept_power;
    logic              overflow;
  } gate_answer_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

  // one row of the directed table; cfg rows carry the register value in power
  typedef struct packed {
    row_op_t           row_op;
    logic              func;
    logic [PWR_W-1:0]  power;
    logic              last;
    logic [QBIN_W-1:0] qbin;
    logic [9:0]        reps;
    logic              typed;
    gate_answer_t      want;
  } step_row_t;

  typedef enum {PK_QUIET, PK_LOUD, PK_SPIKE, PK_EDGE, PK_NOISE} power_kind_t;

  localparam gate_answer_t NO_ANS = '0;

  localparam int N_STEPS = 27;
  localparam step_row_t STEPS [N_STEPS] = '{
    // full spectrum: loud bin 0, silent rest, one dropped load with last
    '{ROW_ITEM, FUNC_LOAD,  31'h7FFFFFFF, 1'b0, 9'd0,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_LOAD,  31'h00000000, 1'b0, 9'h1FF, 10'd511, 1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_LOAD,  31'h55555555, 1'b1, 9'h155, 10'd1,   1'b1,
      '{KIND_SUMMARY, 10'd1, 9'd0, 1'b0, 31'h0, 1'b1}},
    '{ROW_ITEM, FUNC_QUERY, 31'h2AAAAAAA, 1'b1, 9'd0,   10'd1,   1'b1,
      '{KIND_QUERY, 10'd1, 9'd0, 1'b0, 31'h7FFFFFFF, 1'b1}},
    '{ROW_ITEM, FUNC_QUERY, 31'h00000000, 1'b0, 9'd511, 10'd1,   1'b1,
      '{KIND_QUERY, 10'd1, 9'd511, 1'b1, 31'h0, 1'b1}},
    // largest max_power; query before evaluation and beyond count
    '{ROW_CFG,  FUNC_LOAD,  31'h7FFFFFFF, 1'b0, 9'd0,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_LOAD,  31'h7FFFFFFF, 1'b0, 9'd0,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_QUERY, 31'h0,        1'b0, 9'd0,   10'd1,   1'b1,
      '{KIND_QUERY, 10'd0, 9'd0, 1'b0, 31'h7FFFFFFF, 1'b0}},
    '{ROW_ITEM, FUNC_QUERY, 31'h0,        1'b0, 9'd1,   10'd1,   1'b1,
      '{KIND_QUERY, 10'd0, 9'd1, 1'b0, 31'h0, 1'b0}},
    '{ROW_ITEM, FUNC_QUERY, 31'h0,        1'b0, 9'd511, 10'd1,   1'b1,
      '{KIND_QUERY, 10'd0, 9'd511, 1'b0, 31'h0, 1'b0}},
    // two bins: one quiet bin makes a cut at 1
    '{ROW_ITEM, FUNC_LOAD,  31'h0,        1'b1, 9'd0,   10'd1,   1'b1,
      '{KIND_SUMMARY, 10'd1, 9'd0, 1'b0, 31'h0, 1'b0}},
    // single bin: no run, cut equals count
    '{ROW_ITEM, FUNC_LOAD,  31'd5,        1'b1, 9'd0,   10'd1,   1'b1,
      '{KIND_SUMMARY, 10'd1, 9'd0, 1'b0, 31'h0, 1'b0}},
    // isolated spike at bin 2
    '{ROW_ITEM, FUNC_LOAD,  31'h7FFFFFFF, 1'b0, 9'd0,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_LOAD,  31'd10,       1'b0, 9'd0,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_LOAD,  31'h7FFFFFFF, 1'b0, 9'd0,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_LOAD,  31'd10,       1'b0, 9'd0,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_LOAD,  31'h40000000, 1'b0, 9'd0,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_LOAD,  31'h40000000, 1'b1, 9'd0,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_QUERY, 31'h0,        1'b0, 9'd2,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_QUERY, 31'h0,        1'b0, 9'd4,   10'd1,   1'b0, NO_ANS},
    // zero max_power: nothing quiet, spike threshold at zero
    '{ROW_CFG,  FUNC_LOAD,  31'h0,        1'b0, 9'd0,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_LOAD,  31'h0,        1'b0, 9'd0,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_LOAD,  31'd1,        1'b0, 9'd0,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_LOAD,  31'h0,        1'b0, 9'd0,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_LOAD,  31'h0,        1'b1, 9'd0,   10'd1,   1'b0, NO_ANS},
    '{ROW_ITEM, FUNC_QUERY, 31'h0,        1'b0, 9'd1,   10'd1,   1'b0, NO_ANS},
    '{ROW_CFG,  FUNC_LOAD,  31'd1,        1'b0, 9'd0,   10'd1,   1'b0, NO_ANS}
  };

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              start        = 1'b0;
  logic              busy;
  logic              in_func      = FUNC_LOAD;
  logic [PWR_W-1:0]  in_power     = '0;
  logic              in_last      = 1'b0;
  logic [QBIN_W-1:0] in_query_bin = '0;
  logic              cfg_we       = 1'b0;
  logic [PWR_W-1:0]  cfg_wdata    = '0;
  logic              out_strobe;
  logic              out_kind;
  logic [CUT_W-1:0]  out_cut_start;
  logic [QBIN_W-1:0] out_bin_index;
  logic              out_gated;
  logic [PWR_W-1:0]  out_kept_power;
  logic              out_overflow;

  // model state of the gate
  logic [PWR_W-1:0] ref_max = 31'd1;
  logic [PWR_W-1:0] bin_pwr [SQ_MAX_BINS];
  bit               bin_gate [SQ_MAX_BINS];
  int unsigned      nbins = 0;
  int unsigned      tail_at = 0;
  bit               lost = 1'b0;
  bit               spectrum_closed = 1'b0;

  gate_answer_t awaited_answers [$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           cycle_count = 0;
  bit           idle_on = 1'b1;

  always #6 clk = ~clk;

  spectral_quiet_tail_and_spike_gate_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_power      (in_power),
    .in_last       (in_last),
    .in_query_bin  (in_query_bin),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_strobe    (out_strobe),
    .out_kind      (out_kind),
    .out_cut_start (out_cut_start),
    .out_bin_index (out_bin_index),
    .out_gated     (out_gated),
    .out_kept_power(out_kept_power),
    .out_overflow  (out_overflow)
  );

  // power of a bin after gating, zero past the count
  function automatic longint unsigned kept_of(int unsigned i);
    if (i >= nbins || bin_gate[i]) return 0;
    return 64'(bin_pwr[i]);
  endfunction

  // apply one accepted item to the model; returns 1 when it yields an answer
  function automatic bit gate_predict(input logic func, input logic [PWR_W-1:0] pwr,
                                      input logic lst, input logic [QBIN_W-1:0] qbin,
                                      output gate_answer_t ans);
    longint unsigned quiet_ref, spike_ref, p;
    int unsigned     i, run, best_run, best_start;
    ans = '0;
    if (func == FUNC_LOAD) begin
      // first load after a summary opens a new spectrum
      if (spectrum_closed) begin
        nbins = 0;
        tail_at = 0;
        lost = 1'b0;
        spectrum_closed = 1'b0;
      end
      if (nbins < SQ_MAX_BINS) begin
        bin_pwr[nbins] = pwr;
        bin_gate[nbins] = 1'b0;
        nbins++;
      end else begin
        lost = 1'b1;
      end
      if (!lst) return 1'b0;

      quiet_ref = 64'(ref_max) * 2;
      spike_ref = 64'(ref_max) * 3 / 20;
      for (i = 0; i < nbins; i++) bin_gate[i] = 1'b0;

      // first longest run of quiet bins from bin 1
      run = 0;
      best_run = 0;
      best_start = 0;
      for (i = 1; i < nbins; i++) begin
        if (64'(bin_pwr[i]) * 100 < quiet_ref) begin
          run++;
        end else begin
          if (run > best_run) begin
            best_run = run;
            best_start = i - run;
          end
          run = 0;
        end
      end
      if (run > best_run) begin
        best_run = run;
        best_start = nbins - run;
      end

      // tail cut when the run starts further in than what follows it
      tail_at = nbins;
      if (best_start > nbins - (best_start + best_run)) begin
        for (i = best_start; i < nbins; i++) bin_gate[i] = 1'b1;
        tail_at = best_start;
      end

      // spike pass in rising order on kept powers
      for (i = 1; i + 2 < nbins; i++) begin
        p = kept_of(i);
        if (p > spike_ref && kept_of(i - 1) * 100 < 15 * p &&
            kept_of(i + 1) * 100 < 15 * p)
          bin_gate[i] = 1'b1;
      end

      spectrum_closed = 1'b1;
      ans.kind = KIND_SUMMARY;
      ans.cut_start = CUT_W'(tail_at);
      ans.overflow = lost;
      return 1'b1;
    end

    ans.kind = KIND_QUERY;
    ans.cut_start = CUT_W'(tail_at);
    ans.bin_index = qbin;
    if (qbin < nbins) begin
      ans.gated = bin_gate[qbin];
      ans.kept_power = PWR_W'(kept_of(qbin));
    end
    ans.overflow = lost;
    return 1'b1;
  endfunction

  // bin power of a given flavor relative to the current max_power
  function automatic logic [PWR_W-1:0] draw_power(power_kind_t k);
    longint unsigned loud_floor, spike_ref;
    loud_floor = (64'(ref_max) * 2 + 99) / 100;  // lowest power that is not quiet
    spike_ref = 64'(ref_max) * 3 / 20;
    case (k)
      PK_QUIET: begin
        if (loud_floor == 0) return '0;
        return PWR_W'($urandom_range(32'(loud_floor - 1)));
      end
      PK_LOUD:  return PWR_W'($urandom_range(32'h7FFFFFFF, 32'(loud_floor)));
      PK_SPIKE: return PWR_W'($urandom_range(32'h7FFFFFFF, 32'(spike_ref + 1)));
      PK_EDGE: begin
        case ($urandom_range(3))
          0:       return PWR_W'(loud_floor);
          1:       return (loud_floor == 0) ? '0 : PWR_W'(loud_floor - 1);
          2:       return PWR_W'(spike_ref);
          default: return PWR_W'(spike_ref + 1);
        endcase
      end
      default:  return PWR_W'($urandom);
    endcase
  endfunction

  // query bin: mostly inside the spectrum, some just past it, some anywhere
  function automatic logic [QBIN_W-1:0] draw_query_bin();
    int unsigned pick;
    pick = $urandom_range(9);
    if (nbins == 0 || pick >= 8) return QBIN_W'($urandom_range(511));
    if (pick >= 6) return QBIN_W'(nbins + $urandom_range(2));
    return QBIN_W'($urandom_range(nbins - 1));
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  // offer one item and hold it until the block takes it
  task automatic issue(input logic func, input logic [PWR_W-1:0] pwr, input logic lst,
                       input logic [QBIN_W-1:0] qbin, input logic typed,
                       input gate_answer_t want);
    gate_answer_t ans;
    while (idle_on && $urandom_range(99) < 38) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_func <= func;
    in_power <= pwr;
    in_last <= lst;
    in_query_bin <= qbin;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gate_predict(func, pwr, lst, qbin, ans))
      awaited_answers.push_back(typed ? want : ans);
    items_sent++;
  endtask

  // register write once the block has gone quiet
  task automatic write_max_power(input logic [PWR_W-1:0] value);
    start <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ref_max = value;
  endtask

  // one random spectrum: body of segments and optional quiet tail, or pure noise, then queries
  task automatic run_frame();
    logic [PWR_W-1:0] frame_pwr [$];
    logic [PWR_W-1:0] spike;
    longint unsigned  neigh_lim;
    int unsigned      n, tail_len, body_len, pick, k;
    pick = $urandom_range(99);
    if (pick < 2) n = $urandom_range(SQ_MAX_BINS + 8, SQ_MAX_BINS - 8);
    else if (pick < 12) n = $urandom_range(4, 1);
    else n = $urandom_range(48, 5);

    if ($urandom_range(9) == 0) begin
      // pure noise spectrum
      while (frame_pwr.size() < n) frame_pwr.push_back(draw_power(PK_NOISE));
    end else begin
      tail_len = $urandom_range(1) ? $urandom_range(n / 2) : 0;
      body_len = n - tail_len;
      frame_pwr.push_back(draw_power($urandom_range(1) ? PK_LOUD : PK_NOISE));
      while (frame_pwr.size() < body_len) begin
        case ($urandom_range(4))
          0: repeat ($urandom_range(10, 1)) frame_pwr.push_back(draw_power(PK_QUIET));
          1: repeat ($urandom_range(3, 1)) frame_pwr.push_back(draw_power(PK_LOUD));
          2: begin
            // spike with neighbors at or under 15 percent of it
            spike = draw_power(PK_SPIKE);
            neigh_lim = 64'(spike) * 15 / 100;
            frame_pwr.push_back(PWR_W'($urandom_range(32'(neigh_lim))));
            frame_pwr.push_back(spike);
            frame_pwr.push_back(PWR_W'($urandom_range(32'(neigh_lim))));
          end
          3: frame_pwr.push_back(draw_power(PK_EDGE));
          default: frame_pwr.push_back(draw_power(PK_NOISE));
        endcase
      end
      while (frame_pwr.size() > body_len) void'(frame_pwr.pop_back());
      while (frame_pwr.size() < n) frame_pwr.push_back(draw_power(PK_QUIET));
    end

    for (k = 0; k < frame_pwr.size(); k++) begin
      // an occasional query in the middle of the load
      if (k > 0 && $urandom_range(14) == 0)
        issue(FUNC_QUERY, PWR_W'($urandom), 1'($urandom), draw_query_bin(), 1'b0, NO_ANS);
      issue(FUNC_LOAD, frame_pwr[k], k == frame_pwr.size() - 1, QBIN_W'($urandom),
            1'b0, NO_ANS);
    end
    repeat ($urandom_range(6))
      issue(FUNC_QUERY, PWR_W'($urandom), 1'($urandom), draw_query_bin(), 1'b0, NO_ANS);
  endtask

  // result monitor
  always @(posedge clk) begin
    gate_answer_t want;
    if (rst_n && out_strobe) begin
      if (awaited_answers.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual kind %0h bin %0h",
                 $time, out_kind, out_bin_index);
      end else begin
        want = awaited_answers.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("cut_start", 32'(want.cut_start), 32'(out_cut_start));
        check_field("bin_index", 32'(want.bin_index), 32'(out_bin_index));
        check_field("gated", 32'(want.gated), 32'(out_gated));
        check_field("kept_power", 32'(want.kept_power), 32'(out_kept_power));
        check_field("overflow", 32'(want.overflow), 32'(out_overflow));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int          r;
    int          rand_base;
    int          rand_done;
    logic [PWR_W-1:0] new_max;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (r = 0; r < N_STEPS; r++) begin
      if (STEPS[r].row_op == ROW_CFG)
        write_max_power(STEPS[r].power);
      else
        repeat (STEPS[r].reps)
          issue(STEPS[r].func, STEPS[r].power, STEPS[r].last, STEPS[r].qbin,
                STEPS[r].typed, STEPS[r].want);
    end

    // random spectra, with a stretch of back-to-back items
    rand_base = items_sent;
    rand_done = 0;
    while (rand_done < RANDOM_ITEMS) begin
      idle_on = (rand_done < 600) || (rand_done > 950);
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(5))
          0:       new_max = 31'd1;
          1:       new_max = 31'h7FFFFFFF;
          2:       new_max = PWR_W'($urandom_range(5000, 50));
          3:       new_max = PWR_W'($urandom_range(32'h04000000, 32'h00100000));
          4:       new_max = '0;
          default: new_max = PWR_W'($urandom);
        endcase
        write_max_power(new_max);
      end
      run_frame();
      rand_done = items_sent - rand_base;
    end

    // drain
    start <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
